// ===== rtl/core/modulation_curve_evaluator_defines.svh =====
// ----------------------------------------------------------------------------
// Modulation curve evaluator assertion macros
// Shared concurrent-check macros for the evaluator core; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef MODULATION_CURVE_EVALUATOR_DEFINES_SVH
`define MODULATION_CURVE_EVALUATOR_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication check.
`define MCE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication check.
`define MCE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MCE_ASSERT_IMP(lbl, ante, cons)
`define MCE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/mce_pkg.sv =====
// ----------------------------------------------------------------------------
// Modulation curve evaluator package
// Shared constants, types, the 2^-x table and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mce_pkg;

    // Fixed-point format: Q0.16 with one headroom bit for exactly 1.0.
    localparam int          QW    = 17;
    localparam logic [16:0] Q_ONE = 17'd65536;

    // Keyframe table geometry.
    localparam int MAX_KEYS = 16;
    localparam int KEY_AW   = $clog2(MAX_KEYS);
    localparam int KEY_CW   = 5;

    // Exponential table geometry (power of two).
    localparam int          EXP_DEPTH = 256;
    localparam int          EXP_AW    = $clog2(EXP_DEPTH);
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;

    // Divider geometry: numerator and quotient widths.
    localparam int DIV_NW = 33;
    localparam int DIV_QW = 17;

    // Curve mode codes.
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_EASE   = 2'd1;
    localparam logic [1:0] MODE_RUBBER = 2'd2;
    localparam logic [1:0] MODE_KEY    = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_CURVE_MODE = 1'b0;
    localparam logic CFG_KEY_COUNT  = 1'b1;

    // Input action codes.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EASE1,
        ST_EASE2,
        ST_EASE3,
        ST_RUB1,
        ST_RUB2,
        ST_KEY_FIRST,
        ST_KEY_LAST,
        ST_KEY_SCAN,
        ST_KEY_MUL,
        ST_DIV,
        ST_FINISH
    } mce_state_t;

    typedef logic [QW-1:0] exp_tab_t [EXP_DEPTH];

    // Saturate a 17-bit quantity to 1.0.
    function automatic logic [QW-1:0] sat_one(input logic [QW-1:0] v);
        sat_one = (v > Q_ONE) ? Q_ONE : v;
    endfunction

    // Build round(2^16 * 2^(-i/EXP_DEPTH)) with a Q32 Taylor series.
    function automatic exp_tab_t exp_table_build();
        exp_tab_t    tab;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] v;
        for (int i = 0; i < EXP_DEPTH; i++) begin
            y    = (64'(i) * LN2_Q32) >> EXP_AW;
            term = 64'd1 << 32;
            pos  = term;
            neg  = 64'd0;
            for (int k = 1; k <= 20; k++) begin
                term = (term * y) >> 32;
                term = term / 64'(k);
                if ((k % 2) == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            v      = pos - neg;
            tab[i] = QW'((v + 64'd32768) >> 16);
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = exp_table_build();

endpackage

`default_nettype wire

// ===== rtl/core/mce_key_store.sv =====
// ----------------------------------------------------------------------------
// Keyframe store
// Synchronous position and value memories, one write and one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mce_key_store
    import mce_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [KEY_AW-1:0] waddr,
    input  wire logic [QW-1:0]     wpos,
    input  wire logic [QW-1:0]     wval,
    input  wire logic [KEY_AW-1:0] raddr,
    output logic      [QW-1:0]     rpos,
    output logic      [QW-1:0]     rval
);

    logic [QW-1:0] pos_mem [MAX_KEYS];
    logic [QW-1:0] val_mem [MAX_KEYS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            pos_mem[waddr] <= wpos;
            val_mem[waddr] <= wval;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rpos <= pos_mem[raddr];
        rval <= val_mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/mce_divider.sv =====
// ----------------------------------------------------------------------------
// Segment divider
// Restoring divider, one quotient bit per cycle, for interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mce_divider
    import mce_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIV_NW-1:0] num,
    input  wire logic [QW-1:0]     den,
    output logic                   done,
    output logic      [DIV_QW-1:0] quo
);

    localparam int CNT_W = $clog2(DIV_QW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [QW-1:0]     rem_reg, rem_next;
    logic [DIV_QW-1:0] quo_reg, quo_next;
    logic [QW-1:0]     den_reg, den_next;
    logic [QW:0]       trial;
    logic              ge;

    // One restoring step: shift in the next numerator bit and try to subtract.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_QW-1]};
        ge        = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_QW);
            rem_next  = QW'(num[DIV_NW-1:DIV_QW]);
            quo_next  = num[DIV_QW-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? QW'(trial - {1'b0, den_reg}) : trial[QW-1:0];
            quo_next = {quo_reg[DIV_QW-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/modulation_curve_evaluator.sv =====
// ----------------------------------------------------------------------------
// Modulation curve evaluator
// Maps a Q0.16 phase to a Q0.16 modulation level along a selectable curve.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. A keyframe write is absorbed
// and returns nothing. An evaluation returns one level; in keyframe mode its
// time is set by the scan of the keyframe memory (one slot per cycle through
// its single read port, over a keyframe count capped at 16) and by the
// 17-step serial divider that interpolates inside the found segment. A
// finished level waits in an output register, so the next transaction is
// taken while it is held. Configuration is written through its own port;
// the user must write it only while the block is idle, as the block itself
// does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "modulation_curve_evaluator_defines.svh"

module modulation_curve_evaluator
    import mce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [3:0]  key_index,
    input  wire logic [16:0] key_position,
    input  wire logic [16:0] key_value,
    input  wire logic [16:0] phase,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [16:0] level,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [4:0]  cfg_data
);

    localparam int SCW = 16 + EXP_AW;

    mce_state_t         state_reg, state_next;
    logic [1:0]         curve_mode_reg;
    logic [KEY_CW-1:0]  key_count_reg;
    logic [QW-1:0]      t_reg, t_next;
    logic [51:0]        mul_reg, mul_next;
    logic [3:0]         n_reg, n_next;
    logic [QW-1:0]      prev_p_reg, prev_p_next;
    logic [QW-1:0]      prev_v_reg, prev_v_next;
    logic [QW-1:0]      last_v_reg, last_v_next;
    logic [KEY_AW-1:0]  k_reg, k_next;
    logic [QW-1:0]      dv_mag_reg, dv_mag_next;
    logic               dv_neg_reg, dv_neg_next;
    logic [QW-1:0]      dt_reg, dt_next;
    logic [QW-1:0]      seg_reg, seg_next;
    logic [QW-1:0]      res_reg, res_next;
    logic               out_valid_reg;
    logic [QW-1:0]      level_reg;

    logic [KEY_CW-1:0]  cnt_eff;
    logic [KEY_AW-1:0]  last_idx;
    logic [KEY_AW-1:0]  rd_addr;
    logic [QW-1:0]      rd_pos;
    logic [QW-1:0]      rd_val;
    logic               mem_we;
    logic               div_start;
    logic               div_done;
    logic [DIV_QW-1:0]  div_quo;
    logic [DIV_NW-1:0]  div_num;
    logic               out_load;

    // Rubberband and ease datapath terms.
    logic [19:0]        x8;
    logic [SCW-1:0]     scaled;
    logic [EXP_AW-1:0]  idx;
    logic [QW-1:0]      ea;
    logic [QW-1:0]      eb;
    logic [52:0]        ease_sum;
    logic [33:0]        corr;
    logic [QW-1:0]      e_val;
    logic [QW:0]        half;
    logic [QW:0]        m_val;
    logic [QW:0]        lv_sum;

    // Effective keyframe count, capped at the table size.
    assign cnt_eff  = (key_count_reg > KEY_CW'(MAX_KEYS)) ? KEY_CW'(MAX_KEYS) : key_count_reg;
    assign last_idx = KEY_AW'(cnt_eff - KEY_CW'(1));

    mce_key_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (KEY_AW'(key_index)),
        .wpos  (sat_one(key_position)),
        .wval  (sat_one(key_value)),
        .raddr (rd_addr),
        .rpos  (rd_pos),
        .rval  (rd_val)
    );

    mce_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (seg_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Interpolation numerator: |dv| * dt plus half the segment for rounding.
    assign div_num = DIV_NW'(dv_mag_reg * dt_reg) + DIV_NW'(seg_reg >> 1);

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_mode_reg <= MODE_LINEAR;
            key_count_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CURVE_MODE: curve_mode_reg <= cfg_data[1:0];
                CFG_KEY_COUNT:  key_count_reg  <= cfg_data;
                default:        curve_mode_reg <= curve_mode_reg;
            endcase
        end
    end

    // Table lookup terms for the 2^-x interpolation.
    always_comb
    begin
        x8     = {t_reg, 3'b000};
        scaled = SCW'(x8[15:0]) * SCW'(EXP_DEPTH);
        idx    = scaled[SCW-1:16];
        ea     = EXP_TAB[idx];
        if (idx == EXP_AW'(EXP_DEPTH - 1))
        begin
            eb = QW'((EXP_TAB[0] + QW'(1)) >> 1);
        end
        else
        begin
            eb = EXP_TAB[EXP_AW'(idx + EXP_AW'(1))];
        end
        if (eb > ea)
        begin
            eb = ea;
        end
        ease_sum = {1'b0, mul_reg} + (53'd1 << 47);
        corr     = (34'(mul_reg[32:0]) + 34'd32768) >> 16;
        e_val    = prev_v_reg - corr[QW-1:0];
        half     = (n_reg == 4'd0) ? '0 : ((QW+1)'(1) << (n_reg - 4'd1));
        m_val    = ((QW+1)'(e_val) + half) >> n_reg;
        if (m_val > (QW+1)'(Q_ONE))
        begin
            m_val = (QW+1)'(Q_ONE);
        end
    end

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next  = state_reg;
        t_next      = t_reg;
        mul_next    = mul_reg;
        n_next      = n_reg;
        prev_p_next = prev_p_reg;
        prev_v_next = prev_v_reg;
        last_v_next = last_v_reg;
        k_next      = k_reg;
        dv_mag_next = dv_mag_reg;
        dv_neg_next = dv_neg_reg;
        dt_next     = dt_reg;
        seg_next    = seg_reg;
        res_next    = res_reg;
        rd_addr     = '0;
        mem_we      = 1'b0;
        div_start   = 1'b0;
        lv_sum      = '0;
        in_ready    = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ACT_WRITE)
                    begin
                        mem_we = (32'(key_index) < MAX_KEYS);
                    end
                    else
                    begin
                        t_next = sat_one(phase);
                        case (curve_mode_reg)
                            MODE_LINEAR:
                            begin
                                res_next   = sat_one(phase);
                                state_next = ST_FINISH;
                            end
                            MODE_EASE:   state_next = ST_EASE1;
                            MODE_RUBBER: state_next = ST_RUB1;
                            MODE_KEY:
                            begin
                                if (cnt_eff == '0)
                                begin
                                    res_next   = sat_one(phase);
                                    state_next = ST_FINISH;
                                end
                                else
                                begin
                                    rd_addr    = '0;
                                    state_next = ST_KEY_FIRST;
                                end
                            end
                            default:     state_next = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_EASE1:
            begin
                mul_next   = 52'(t_reg * t_reg);
                state_next = ST_EASE2;
            end
            ST_EASE2:
            begin
                mul_next   = mul_reg[33:0] * (18'(3 * 65536) - {t_reg, 1'b0});
                state_next = ST_EASE3;
            end
            ST_EASE3:
            begin
                res_next   = sat_one(QW'(ease_sum[52:48]));
                state_next = ST_FINISH;
            end
            ST_RUB1:
            begin
                mul_next    = 52'((ea - eb) * scaled[15:0]);
                prev_v_next = ea;
                n_next      = x8[19:16];
                state_next  = ST_RUB2;
            end
            ST_RUB2:
            begin
                res_next   = Q_ONE - m_val[QW-1:0];
                state_next = ST_FINISH;
            end
            ST_KEY_FIRST:
            begin
                prev_p_next = rd_pos;
                prev_v_next = rd_val;
                if ((cnt_eff == KEY_CW'(1)) || (t_reg <= rd_pos))
                begin
                    res_next   = rd_val;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_addr    = last_idx;
                    state_next = ST_KEY_LAST;
                end
            end
            ST_KEY_LAST:
            begin
                last_v_next = rd_val;
                if (t_reg >= rd_pos)
                begin
                    res_next   = rd_val;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_addr    = KEY_AW'(1);
                    k_next     = KEY_AW'(1);
                    state_next = ST_KEY_SCAN;
                end
            end
            ST_KEY_SCAN:
            begin
                // The read data is slot k; the previous slot sits in prev_*.
                if ((t_reg >= prev_p_reg) && (t_reg <= rd_pos))
                begin
                    if (rd_pos <= prev_p_reg)
                    begin
                        res_next   = prev_v_reg;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        dv_neg_next = (rd_val < prev_v_reg);
                        dv_mag_next = (rd_val < prev_v_reg) ? (prev_v_reg - rd_val)
                                                            : (rd_val - prev_v_reg);
                        dt_next     = t_reg - prev_p_reg;
                        seg_next    = rd_pos - prev_p_reg;
                        state_next  = ST_KEY_MUL;
                    end
                end
                else if (k_reg == last_idx)
                begin
                    res_next   = last_v_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    prev_p_next = rd_pos;
                    prev_v_next = rd_val;
                    k_next      = KEY_AW'(k_reg + KEY_AW'(1));
                    rd_addr     = KEY_AW'(k_reg + KEY_AW'(1));
                end
            end
            ST_KEY_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (dv_neg_reg)
                    begin
                        res_next = ((QW+1)'(div_quo) > (QW+1)'(prev_v_reg)) ? '0
                                 : QW'(prev_v_reg - QW'(div_quo));
                    end
                    else
                    begin
                        lv_sum   = (QW+1)'(prev_v_reg) + (QW+1)'(div_quo);
                        res_next = (lv_sum > (QW+1)'(Q_ONE)) ? Q_ONE : lv_sum[QW-1:0];
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // The result moves to the output register once that register is free.
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        mul_reg    <= mul_next;
        n_reg      <= n_next;
        prev_p_reg <= prev_p_next;
        prev_v_reg <= prev_v_next;
        last_v_reg <= last_v_next;
        k_reg      <= k_next;
        dv_mag_reg <= dv_mag_next;
        dv_neg_reg <= dv_neg_next;
        dt_reg     <= dt_next;
        seg_reg    <= seg_next;
        res_reg    <= res_next;
        if (out_load)
        begin
            level_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;

    // A held level never exceeds 1.0.
    `MCE_ASSERT_IMP(a_level_range, out_valid_reg, level_reg <= Q_ONE)
    // A keyframe write leaves the sequencer idle.
    `MCE_ASSERT_NXT(a_write_no_work, in_valid && in_ready && (action == ACT_WRITE),
                    state_reg == ST_IDLE)
    // The divider's completion always retires the evaluation.
    `MCE_ASSERT_NXT(a_div_retire, (state_reg == ST_DIV) && div_done, state_reg == ST_FINISH)
    // The keyframe scan only runs in keyframe mode.
    `MCE_ASSERT_IMP(a_scan_mode, state_reg == ST_KEY_SCAN, curve_mode_reg == MODE_KEY)

endmodule

`default_nettype wire
